// ----- rtl/core/ctt_pkg.sv -----
// Shared types, token codes and character constants of the config text tokenizer.
package ctt_pkg;

   localparam int unsigned LINE_BITS_DEF = 16;

   // result queue
   localparam int unsigned OUT_DEPTH = 4;
   localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int unsigned OUT_LVL_W = OUT_PTR_W + 1;

   typedef logic [15:0] line_num_type;

   // token kinds
   localparam logic [3:0] KIND_EOF     = 4'd0;
   localparam logic [3:0] KIND_EQUALS  = 4'd1;
   localparam logic [3:0] KIND_COMMA   = 4'd2;
   localparam logic [3:0] KIND_DOT     = 4'd3;
   localparam logic [3:0] KIND_LPAREN  = 4'd4;
   localparam logic [3:0] KIND_RPAREN  = 4'd5;
   localparam logic [3:0] KIND_LSECT   = 4'd6;
   localparam logic [3:0] KIND_RSECT   = 4'd7;
   localparam logic [3:0] KIND_LCURLY  = 4'd8;
   localparam logic [3:0] KIND_RCURLY  = 4'd9;
   localparam logic [3:0] KIND_AT      = 4'd10;
   localparam logic [3:0] KIND_IDENT   = 4'd11;
   localparam logic [3:0] KIND_STRING  = 4'd12;
   localparam logic [3:0] KIND_ERROR   = 4'd13;

   // lexer modes
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_IDENT = 2'd1;
   localparam logic [1:0] MODE_STR   = 2'd2;
   localparam logic [1:0] MODE_ESC   = 2'd3;

   // characters
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_NL         = 8'h0A;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;
   localparam logic [7:0] CHAR_COMMA      = 8'h2C;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_DIG_0      = 8'h30;
   localparam logic [7:0] CHAR_DIG_9      = 8'h39;
   localparam logic [7:0] CHAR_EQUALS     = 8'h3D;
   localparam logic [7:0] CHAR_AT         = 8'h40;
   localparam logic [7:0] CHAR_UP_A       = 8'h41;
   localparam logic [7:0] CHAR_UP_Z       = 8'h5A;
   localparam logic [7:0] CHAR_LSECT      = 8'h5B;
   localparam logic [7:0] CHAR_BSLASH     = 8'h5C;
   localparam logic [7:0] CHAR_RSECT      = 8'h5D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LO_A       = 8'h61;
   localparam logic [7:0] CHAR_LO_N       = 8'h6E;
   localparam logic [7:0] CHAR_LO_T       = 8'h74;
   localparam logic [7:0] CHAR_LO_Z       = 8'h7A;
   localparam logic [7:0] CHAR_LCURLY     = 8'h7B;
   localparam logic [7:0] CHAR_RCURLY     = 8'h7D;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [3:0]   token_kind;
      logic [7:0]   text_byte;
      logic         text_valid;
      logic         token_last;
      line_num_type line_number;
   } rsp_type;

   // results of one lexed byte, first result in r0
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
   } lex_push_type;

   typedef struct packed {
      logic                 room;
      logic [OUT_LVL_W-1:0] level;
   } fifo_status_type;

endpackage

// ----- rtl/core/ctt_lexer.sv -----
// Input register, lexer state and per-byte token logic.
module ctt_lexer #(
   parameter int unsigned LINE_BITS = ctt_pkg::LINE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ctt_pkg::req_type          req_data,
   input  logic                      csr_write,
   input  logic [15:0]               csr_data,
   input  ctt_pkg::fifo_status_type  fifo_status,
   output ctt_pkg::lex_push_type     push
);

   ctt_pkg::req_type     in_ff;
   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           mode_ff, mode_in;
   logic [7:0]           held_ff, held_in;
   logic                 hv_ff, hv_in;
   logic [LINE_BITS-1:0] line_ff, line_in;

   logic       fire, accept;
   logic [7:0] b;
   logic       eoi;
   ctt_pkg::line_num_type cur_line;

   logic [1:0]       n;
   ctt_pkg::rsp_type r0, r1;
   logic             line_inc;

   // idle-mode outcome of b
   logic             idle_emit;
   ctt_pkg::rsp_type idle_res;
   logic [1:0]       idle_mode;
   logic             idle_hv;
   logic             idle_nl;

   logic       esc_plain;
   logic [7:0] esc_byte;

   function automatic logic is_alnum_(input logic [7:0] c);
      return (c >= ctt_pkg::CHAR_DIG_0 && c <= ctt_pkg::CHAR_DIG_9) ||
             (c >= ctt_pkg::CHAR_LO_A && c <= ctt_pkg::CHAR_LO_Z) ||
             (c >= ctt_pkg::CHAR_UP_A && c <= ctt_pkg::CHAR_UP_Z) ||
             c == ctt_pkg::CHAR_UNDERSCORE;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == ctt_pkg::CHAR_SPACE || (c >= ctt_pkg::CHAR_TAB && c <= ctt_pkg::CHAR_CR);
   endfunction

   // KIND_EOF means not punctuation
   function automatic logic [3:0] punct_kind(input logic [7:0] c);
      logic [3:0] k;
      unique case (c)
         ctt_pkg::CHAR_EQUALS: k = ctt_pkg::KIND_EQUALS;
         ctt_pkg::CHAR_COMMA:  k = ctt_pkg::KIND_COMMA;
         ctt_pkg::CHAR_DOT:    k = ctt_pkg::KIND_DOT;
         ctt_pkg::CHAR_LPAREN: k = ctt_pkg::KIND_LPAREN;
         ctt_pkg::CHAR_RPAREN: k = ctt_pkg::KIND_RPAREN;
         ctt_pkg::CHAR_LSECT:  k = ctt_pkg::KIND_LSECT;
         ctt_pkg::CHAR_RSECT:  k = ctt_pkg::KIND_RSECT;
         ctt_pkg::CHAR_LCURLY: k = ctt_pkg::KIND_LCURLY;
         ctt_pkg::CHAR_RCURLY: k = ctt_pkg::KIND_RCURLY;
         ctt_pkg::CHAR_AT:     k = ctt_pkg::KIND_AT;
         default:              k = ctt_pkg::KIND_EOF;
      endcase
      return k;
   endfunction

   function automatic ctt_pkg::rsp_type mk(input logic [3:0] kind, input logic [7:0] tb,
                                           input logic tv, input logic tl,
                                           input ctt_pkg::line_num_type ln);
      ctt_pkg::rsp_type r;
      r.token_kind  = kind;
      r.text_byte   = tb;
      r.text_valid  = tv;
      r.token_last  = tl;
      r.line_number = ln;
      return r;
   endfunction

   assign fire      = in_valid_ff && fifo_status.room;
   assign req_stall = in_valid_ff && !fifo_status.room;
   assign accept    = req_valid && !req_stall;
   assign b         = in_ff.in_byte;
   assign eoi       = in_ff.end_of_input;
   assign cur_line  = ctt_pkg::line_num_type'(line_ff);

   always_comb begin
      idle_emit = 1'b0;
      idle_res  = mk(ctt_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, cur_line);
      idle_mode = ctt_pkg::MODE_IDLE;
      idle_hv   = 1'b0;
      idle_nl   = 1'b0;
      if (b == ctt_pkg::CHAR_NL) begin
         idle_nl = 1'b1;
      end else if (is_space(b)) begin
         idle_emit = 1'b0;
      end else if (punct_kind(b) != ctt_pkg::KIND_EOF) begin
         idle_emit = 1'b1;
         idle_res  = mk(punct_kind(b), 8'd0, 1'b0, 1'b1, cur_line);
      end else if (b == ctt_pkg::CHAR_QUOTE) begin
         idle_mode = ctt_pkg::MODE_STR;
      end else if (is_alnum_(b)) begin
         idle_mode = ctt_pkg::MODE_IDENT;
         idle_hv   = 1'b1;
      end else begin
         idle_emit = 1'b1;
         idle_res  = mk(ctt_pkg::KIND_ERROR, b, 1'b1, 1'b1, cur_line);
      end
   end

   always_comb begin
      esc_plain = 1'b0;
      esc_byte  = b;
      if (b == ctt_pkg::CHAR_QUOTE || b == ctt_pkg::CHAR_BSLASH) begin
         esc_byte = b;
      end else if (b == ctt_pkg::CHAR_LO_N) begin
         esc_byte = ctt_pkg::CHAR_NL;
      end else if (b == ctt_pkg::CHAR_LO_T) begin
         esc_byte = ctt_pkg::CHAR_TAB;
      end else begin
         esc_plain = 1'b1;
      end
   end

   always_comb begin
      n        = 2'd0;
      r0       = mk(ctt_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, cur_line);
      r1       = mk(ctt_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, cur_line);
      mode_in  = mode_ff;
      held_in  = held_ff;
      hv_in    = hv_ff;
      line_inc = 1'b0;
      if (eoi) begin
         mode_in = ctt_pkg::MODE_IDLE;
         hv_in   = 1'b0;
         held_in = 8'd0;
         unique case (mode_ff)
            ctt_pkg::MODE_IDENT: begin
               n  = 2'd2;
               r0 = mk(ctt_pkg::KIND_IDENT, held_ff, 1'b1, 1'b1, cur_line);
            end
            ctt_pkg::MODE_STR, ctt_pkg::MODE_ESC: begin
               n  = 2'd2;
               r0 = mk(ctt_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1, cur_line);
            end
            default: begin
               n = 2'd1;
            end
         endcase
      end else begin
         unique case (mode_ff)
            ctt_pkg::MODE_IDENT: begin
               if (is_alnum_(b) || b == ctt_pkg::CHAR_DOT) begin
                  n       = 2'd1;
                  r0      = mk(ctt_pkg::KIND_IDENT, held_ff, 1'b1, 1'b0, cur_line);
                  held_in = b;
               end else begin
                  r0       = mk(ctt_pkg::KIND_IDENT, held_ff, 1'b1, 1'b1, cur_line);
                  r1       = idle_res;
                  n        = idle_emit ? 2'd2 : 2'd1;
                  mode_in  = idle_mode;
                  hv_in    = idle_hv;
                  held_in  = b;
                  line_inc = idle_nl;
               end
            end
            ctt_pkg::MODE_STR: begin
               if (b == ctt_pkg::CHAR_QUOTE) begin
                  n       = 2'd1;
                  r0      = hv_ff ? mk(ctt_pkg::KIND_STRING, held_ff, 1'b1, 1'b1, cur_line)
                                  : mk(ctt_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1, cur_line);
                  hv_in   = 1'b0;
                  mode_in = ctt_pkg::MODE_IDLE;
               end else if (b == ctt_pkg::CHAR_BSLASH) begin
                  mode_in = ctt_pkg::MODE_ESC;
               end else begin
                  n       = hv_ff ? 2'd1 : 2'd0;
                  r0      = mk(ctt_pkg::KIND_STRING, held_ff, 1'b1, 1'b0, cur_line);
                  held_in = b;
                  hv_in   = 1'b1;
               end
            end
            ctt_pkg::MODE_ESC: begin
               mode_in = ctt_pkg::MODE_STR;
               hv_in   = 1'b1;
               held_in = esc_byte;
               if (!esc_plain) begin
                  n  = hv_ff ? 2'd1 : 2'd0;
                  r0 = mk(ctt_pkg::KIND_STRING, held_ff, 1'b1, 1'b0, cur_line);
               end else if (hv_ff) begin
                  // unknown escape keeps the backslash
                  n  = 2'd2;
                  r0 = mk(ctt_pkg::KIND_STRING, held_ff, 1'b1, 1'b0, cur_line);
                  r1 = mk(ctt_pkg::KIND_STRING, ctt_pkg::CHAR_BSLASH, 1'b1, 1'b0, cur_line);
               end else begin
                  n  = 2'd1;
                  r0 = mk(ctt_pkg::KIND_STRING, ctt_pkg::CHAR_BSLASH, 1'b1, 1'b0, cur_line);
               end
            end
            default: begin
               r0       = idle_res;
               n        = idle_emit ? 2'd1 : 2'd0;
               mode_in  = idle_mode;
               hv_in    = idle_hv;
               held_in  = b;
               line_inc = idle_nl;
            end
         endcase
      end
   end

   always_comb begin
      line_in = line_ff;
      if (line_inc && line_ff != '1) begin
         line_in = line_ff + LINE_BITS'(1);
      end
   end

   assign in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   assign push.count = fire ? n : 2'd0;
   assign push.r0    = r0;
   assign push.r1    = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= ctt_pkg::MODE_IDLE;
         hv_ff       <= 1'b0;
         line_ff     <= LINE_BITS'(1);
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write) begin
            line_ff <= LINE_BITS'(csr_data);
         end else if (fire) begin
            line_ff <= line_in;
         end
         if (fire) begin
            mode_ff <= mode_in;
            hv_ff   <= hv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (fire) begin
         held_ff <= held_in;
      end
   end

endmodule

// ----- rtl/core/ctt_out_fifo.sv -----
// Result queue taking up to two results per cycle and giving one per cycle while rsp_stall is low.
module ctt_out_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  ctt_pkg::lex_push_type    push,
   output ctt_pkg::fifo_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ctt_pkg::rsp_type         rsp_data
);

   ctt_pkg::rsp_type                 mem_ff [ctt_pkg::OUT_DEPTH];
   logic [ctt_pkg::OUT_PTR_W-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [ctt_pkg::OUT_LVL_W-1:0]    level_ff, level_in;
   logic                             pop;
   logic [ctt_pkg::OUT_PTR_W-1:0]    wptr_next;

   assign rsp_valid = level_ff != '0;
   assign rsp_data  = mem_ff[rptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wptr_next = wptr_ff + ctt_pkg::OUT_PTR_W'(1);

   assign wptr_in  = wptr_ff + ctt_pkg::OUT_PTR_W'(push.count);
   assign rptr_in  = rptr_ff + ctt_pkg::OUT_PTR_W'(pop);
   assign level_in = level_ff + ctt_pkg::OUT_LVL_W'(push.count) - ctt_pkg::OUT_LVL_W'(pop);

   assign status.level = level_ff;
   assign status.room  = level_ff <= ctt_pkg::OUT_LVL_W'(ctt_pkg::OUT_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         level_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wptr_next] <= push.r1;
      end
   end

endmodule

// ----- rtl/core/config_text_tokenizer_unit.sv -----
// Top level of the config text tokenizer: lexer stage and result queue.
//
// Usage:
//   req_* carries one text byte per transaction, or an end-of-input mark that
//   closes any open token and yields an end-of-file token. rsp_* carries one
//   result per transaction: a punctuation, error or eof token, or one byte of
//   identifier or string text; token_last flags the final result of a token.
//   csr_* writes the start line number (always ready); write it only while the
//   block is idle. It also reloads the running line counter.
// Timing:
//   A byte is captured in the input register and lexed, once the queue has room,
//   into a four-entry result queue, whose registered entries are offered on
//   rsp_*. One byte per cycle is accepted while the queue holds at most two
//   results; a byte gives zero, one or two results, and the output side drains
//   one result per cycle while rsp_stall is low.
// Reset and stall:
//   Reset empties the input register and queue, sets the mode to idle and the
//   line counter to 1. When rsp_stall holds, results wait in the queue; once it
//   is too full for another byte, req_stall rises while the input register is
//   occupied. Nothing is dropped.
module config_text_tokenizer_unit #(
   parameter int unsigned LINE_BITS = ctt_pkg::LINE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ctt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ctt_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   ctt_pkg::lex_push_type    push;
   ctt_pkg::fifo_status_type fifo_status;

   assign csr_ready = 1'b1;

   ctt_lexer #(
      .LINE_BITS(LINE_BITS)
   ) u_lexer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .fifo_status (fifo_status),
      .push        (push)
   );

   ctt_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .status    (fifo_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= ctt_pkg::OUT_LVL_W'(ctt_pkg::OUT_DEPTH))
      else $error("result queue overflow");

   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == ctt_pkg::KIND_EOF |->
         rsp_data.token_last && !rsp_data.text_valid)
      else $error("eof token without last flag or with text");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !fifo_status.room)
      else $error("input stalled while queue has room");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule
